### design/sdec_pkg.sv
// ----------------------------------------------------------------------------
// sdec_pkg: shared types and constants for the decimal text converter
// Holds the sequencer states, the digit stack control group, character codes
// and the reciprocal used for division by ten.
// ----------------------------------------------------------------------------
package sdec_pkg;

    // Stream widths. Input tdata packs value and min_width, output tdata the
    // character, both padded with zeros to whole bytes.
    localparam int VALUE_W    = 32;
    localparam int WIDTH_W    = 5;
    localparam int CHAR_W     = 6;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;

    // Longest text: ten digits and a minus sign.
    localparam int DIGIT_DEPTH = 11;
    localparam int DIGIT_IDX_W = 4;
    localparam int DIGIT_CNT_W = 4;

    // Quotient of a 32-bit value by ten fits in 29 bits.
    localparam int QUOT_W = 29;
    localparam int PROD_W = 64;

    localparam logic [WIDTH_W-1:0] MAX_WIDTH = 5'd31;

    localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
    localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
    localparam logic [CHAR_W-1:0] CH_SPACE = 6'd32;

    // floor(x / 10) == (x * RECIP_TEN) >> 35 for every 32-bit x.
    localparam logic [VALUE_W-1:0] RECIP_TEN = 32'hCCCC_CCCD;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_REM,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
    } t_stack_ctrl;

endpackage

### design/sdec_div10.sv
// ----------------------------------------------------------------------------
// sdec_div10: divide-by-ten unit
// Multiplies by the reciprocal of ten into a register; the following cycle
// yields the quotient and the remainder digit of the same, unchanged operand.
// ----------------------------------------------------------------------------
module sdec_div10
    import sdec_pkg::*;
(
    input  logic               i_clk,
    input  logic [VALUE_W-1:0] i_mag,
    output logic [QUOT_W-1:0]  o_quot,
    output logic [3:0]         o_rem
);

    logic [PROD_W-1:0]  r_prod;
    logic [VALUE_W-1:0] w_diff;

    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_mag) * PROD_W'(RECIP_TEN);
    end

    assign o_quot = r_prod[PROD_W-1:35];

    // The remainder is below ten, so its low four bits are exact.
    assign w_diff = i_mag - {o_quot, 3'b000} - {2'b00, o_quot, 1'b0};
    assign o_rem  = w_diff[3:0];

endmodule

### design/sdec_digit_stack.sv
// ----------------------------------------------------------------------------
// sdec_digit_stack: character stack
// Digits arrive least significant first and leave most significant first.
// ----------------------------------------------------------------------------
module sdec_digit_stack
    import sdec_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_stack_ctrl            i_ctrl,
    input  logic [CHAR_W-1:0]      i_char,
    output logic [CHAR_W-1:0]      o_top,
    output logic [DIGIT_CNT_W-1:0] o_count
);

    logic [CHAR_W-1:0]      r_mem [DIGIT_DEPTH];
    logic [DIGIT_CNT_W-1:0] r_count;
    logic [DIGIT_IDX_W-1:0] w_top_idx;

    assign w_top_idx = (r_count == '0) ? '0 : DIGIT_IDX_W'(r_count - 1'b1);
    assign o_top     = r_mem[w_top_idx];
    assign o_count   = r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.push) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctrl.pop) begin
            r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_mem[DIGIT_IDX_W'(r_count)] <= i_char;
        end
    end

endmodule

### design/signed_int_to_padded_decimal_ascii.sv
// ----------------------------------------------------------------------------
// signed_int_to_padded_decimal_ascii: signed integer to padded decimal text
// Converts a 32-bit two's complement value to its decimal ASCII characters.
// ----------------------------------------------------------------------------
// Each input beat carries a value and a minimum field width. The block sends
// the decimal text as a run of output beats, one character per beat, most
// significant character first: leading spaces up to the field width, then a
// minus sign for a negative value, then the digits. Zero is a single '0', and
// the most negative value prints correctly. The final beat of a run carries
// tlast; no terminator is sent. A width above 31 is clamped to 31. One beat
// is taken, then the block is busy: each digit passes through the shared
// divide-by-ten unit (a 32x32 reciprocal multiply, then the remainder), a
// further state places the sign and the pad count, and one character leaves
// per cycle while the output side is ready. The one-character output register
// holds a finished character while a new input beat is already accepted.
// ----------------------------------------------------------------------------
module signed_int_to_padded_decimal_ascii
    import sdec_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    // [31:0] value, [36:32] field_width, [39:37] zero
    input  logic [IN_DATA_W-1:0]  i_s_tdata,
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    // [5:0] text_char, [7:6] zero
    output logic [OUT_DATA_W-1:0] o_m_tdata,
    output logic                  o_m_tlast
);

    t_state                 r_state, n_state;
    logic [VALUE_W-1:0]     r_mag;
    logic                   r_neg;
    logic [WIDTH_W-1:0]     r_width;
    logic [WIDTH_W-1:0]     r_pad;
    logic                   r_out_valid;
    logic [CHAR_W-1:0]      r_out_char;
    logic                   r_out_last;

    logic [QUOT_W-1:0]      w_quot;
    logic [3:0]             w_rem;
    t_stack_ctrl            w_stack;
    logic [CHAR_W-1:0]      w_push_char;
    logic [CHAR_W-1:0]      w_top;
    logic [DIGIT_CNT_W-1:0] w_count;

    logic                   w_accept;
    logic                   w_out_load;
    logic [CHAR_W-1:0]      w_char;
    logic                   w_last;
    logic [WIDTH_W-1:0]     w_text_len;
    logic [WIDTH_W-1:0]     w_in_width;
    logic [VALUE_W-1:0]     w_in_value;

    sdec_div10 u_div10 (
        .i_clk  (i_clk),
        .i_mag  (r_mag),
        .o_quot (w_quot),
        .o_rem  (w_rem)
    );

    sdec_digit_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_stack),
        .i_char  (w_push_char),
        .o_top   (w_top),
        .o_count (w_count)
    );

    assign w_in_value = i_s_tdata[VALUE_W-1:0];
    assign w_in_width = i_s_tdata[VALUE_W +: WIDTH_W];
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Text length once the sign is placed; the stack still lacks the sign.
    assign w_text_len = WIDTH_W'(w_count) + WIDTH_W'(r_neg);

    // Spaces go first; the character that empties the stack ends the run.
    assign w_char = (r_pad != '0) ? CH_SPACE : w_top;
    assign w_last = (r_pad == '0) && (w_count == DIGIT_CNT_W'(1));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = ST_MUL;
                end
            end
            ST_MUL: begin
                n_state = ST_REM;
            end
            ST_REM: begin
                n_state = (w_quot != '0) ? ST_MUL : ST_FIN;
            end
            ST_FIN: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (w_out_load && w_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        o_s_tready    = 1'b0;
        w_out_load    = 1'b0;
        w_stack       = '0;
        w_push_char   = CH_MINUS;
        case (r_state)
            ST_IDLE: begin
                o_s_tready    = 1'b1;
                w_stack.clear = w_accept;
            end
            ST_REM: begin
                w_stack.push = 1'b1;
                w_push_char  = CH_ZERO + CHAR_W'(w_rem);
            end
            ST_FIN: begin
                w_stack.push = r_neg;
            end
            ST_EMIT: begin
                w_out_load  = !r_out_valid || i_m_tready;
                w_stack.pop = w_out_load && (r_pad == '0);
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Working registers of the conversion.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_neg   <= w_in_value[VALUE_W-1];
            r_mag   <= w_in_value[VALUE_W-1] ? (VALUE_W'(0) - w_in_value) : w_in_value;
            r_width <= (w_in_width > MAX_WIDTH) ? MAX_WIDTH : w_in_width;
        end else if (r_state == ST_REM) begin
            r_mag <= VALUE_W'(w_quot);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_FIN) begin
            r_pad <= (r_width > w_text_len) ? (r_width - w_text_len) : '0;
        end else if (w_out_load && (r_pad != '0)) begin
            r_pad <= r_pad - 1'b1;
        end
    end

    // Output register: holds a character until the downstream side takes it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_char <= w_char;
            r_out_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_char};
    assign o_m_tlast  = r_out_last;

endmodule

### design/sdec_checker.sv
// ----------------------------------------------------------------------------
// sdec_checker: port-level checks for the decimal text converter
// Watches the stream ports of the top level and is bound to it.
// ----------------------------------------------------------------------------
module sdec_checker
    import sdec_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_tvalid,
    input logic                  o_s_tready,
    input logic                  o_m_tvalid,
    input logic                  i_m_tready,
    input logic [OUT_DATA_W-1:0] o_m_tdata,
    input logic                  o_m_tlast
);

    // A stalled output beat keeps its character and end mark.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("output beat changed while stalled");

    // Once a beat is taken the block is busy converting it.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("ready high right after an accepted input beat");

    // Only a space, a minus sign or a digit ever leaves the block.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ((o_m_tdata == OUT_DATA_W'(CH_SPACE))
                        || (o_m_tdata == OUT_DATA_W'(CH_MINUS))
                        || ((o_m_tdata >= OUT_DATA_W'(CH_ZERO))
                            && (o_m_tdata <= OUT_DATA_W'(CH_ZERO) + 8'd9))))
        else $error("output character outside the text alphabet");

    // A new item is taken only after the previous run reached its end mark.
    a_run_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |-> !(o_m_tvalid && !o_m_tlast))
        else $error("input accepted in the middle of a character run");

endmodule

bind signed_int_to_padded_decimal_ascii sdec_checker u_sdec_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
